>>> design/ccr_pkg.sv
// Shared types and constants for the cartridge clock registers block.
// This package has no dependencies. The core, the output stage and the top level use it.
`timescale 1ns / 1ps
`default_nettype none

package ccr_pkg;

	// These are the request kinds.
	typedef enum logic [1:0] {
		MODE_TICK  = 2'd0,
		MODE_READ  = 2'd1,
		MODE_WRITE = 2'd2,
		MODE_LATCH = 2'd3
	} mode_t;

	// These are the register indexes seen on the bus.
	localparam logic [7:0] REG_SEC  = 8'd8;
	localparam logic [7:0] REG_MIN  = 8'd9;
	localparam logic [7:0] REG_HOUR = 8'd10;
	localparam logic [7:0] REG_DAYL = 8'd11;
	localparam logic [7:0] REG_CTRL = 8'd12;

	localparam int unsigned NUM_REGS = 5;

	localparam logic [5:0] SEC_LAST  = 6'd59;
	localparam logic [5:0] MIN_LAST  = 6'd59;
	localparam logic [4:0] HOUR_LAST = 5'd23;
	localparam logic [8:0] DAY_LAST  = 9'd511;

	localparam logic [7:0] UNKNOWN_READ = 8'hFF;
	localparam logic [7:0] LATCH_SET    = 8'h01;
	localparam logic [7:0] LATCH_CLEAR  = 8'h00;

	// This is one request as it is presented to the clock core.
	typedef struct packed {
		logic       go;
		mode_t      mode;
		logic [7:0] idx;
		logic [7:0] val;
	} cmd_t;

endpackage

`default_nettype wire

>>> design/cartridge_clock_registers.sv
// This is the top level of the cartridge clock registers block: an input register, the clock core and the result register.
// It depends on ccr_pkg, ccr_core and ccr_out.
`timescale 1ns / 1ps
`default_nettype none

// This block is a real-time clock with bus-style register access. Every request carries a
// mode. A tick advances seconds, minutes, hours and the 9-bit day count by one second,
// unless the halt flag is set. When the day count passes 511, the sticky day-carry flag
// is set. A read of registers 8 to 12 returns the live value, or the latched snapshot
// while the latch is held. A read of any other index returns 255. Each read returns
// exactly one result. A write loads the selected register through its field mask. A
// latch-control write of 1 takes a snapshot and holds it. A write of 0 releases the
// latch. Ticks, writes and latch writes return no result. While a request sits in the
// input register, the core forms the read value, and the core state is updated as the
// request completes. A read result then sits in the output register until it is taken.
// A new request can be accepted every cycle unless the input stalls. The input stalls
// only while a read waits behind a full output register that is itself stalled. An
// accepted read passes through the input register and then the output register.
module cartridge_clock_registers (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] mode,
	input  wire logic [7:0] reg_index,
	input  wire logic [7:0] write_value,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      read_data
);
	import ccr_pkg::*;

	logic       valid_s1;
	mode_t      mode_s1;
	logic [7:0] idx_s1;
	logic [7:0] val_s1;

	logic       out_free;
	logic       is_read;
	logic       go;
	logic [7:0] rd_byte;
	cmd_t       cmd;

	// A request in the input register completes this cycle, unless it is a read and the
	// result register cannot take its value.
	assign is_read  = (mode_s1 == MODE_READ);
	assign go       = valid_s1 && (!is_read || out_free);
	assign in_stall = valid_s1 && !go;

	assign cmd.go   = go;
	assign cmd.mode = mode_s1;
	assign cmd.idx  = idx_s1;
	assign cmd.val  = val_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mode_s1 <= mode_t'(mode);
			idx_s1  <= reg_index;
			val_s1  <= write_value;
		end
	end

	ccr_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.rd_byte (rd_byte)
	);

	ccr_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (go && is_read),
		.data      (rd_byte),
		.out_stall (out_stall),
		.out_free  (out_free),
		.out_valid (out_valid),
		.read_data (read_data)
	);

endmodule

`default_nettype wire

>>> design/ccr_core.sv
// This file holds the clock core: the time counters, the control flags, the latched snapshot and the read mux.
// It depends on ccr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ccr_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire ccr_pkg::cmd_t cmd,
	output logic [7:0]       rd_byte
);
	import ccr_pkg::*;

	logic [5:0] sec_q;
	logic [5:0] min_q;
	logic [4:0] hour_q;
	logic [8:0] day_q;
	logic       carry_q;
	logic       halt_q;
	logic       latched_q;
	logic [7:0] snap_q [NUM_REGS];

	logic [7:0] live [NUM_REGS];
	logic [7:0] rel_idx;
	logic [2:0] sel;

	assign live[0] = {2'b00, sec_q};
	assign live[1] = {2'b00, min_q};
	assign live[2] = {3'b000, hour_q};
	assign live[3] = day_q[7:0];
	assign live[4] = {carry_q, halt_q, 5'b00000, day_q[8]};

	assign rel_idx = cmd.idx - REG_SEC;
	assign sel     = rel_idx[2:0];

	always_comb begin
		if (cmd.idx >= REG_SEC && cmd.idx <= REG_CTRL) begin
			rd_byte = latched_q ? snap_q[sel] : live[sel];
		end else begin
			rd_byte = UNKNOWN_READ;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q     <= '0;
			min_q     <= '0;
			hour_q    <= '0;
			day_q     <= '0;
			carry_q   <= 1'b0;
			halt_q    <= 1'b0;
			latched_q <= 1'b0;
			for (int k = 0; k < NUM_REGS; k++) begin
				snap_q[k] <= '0;
			end
		end else if (cmd.go) begin
			unique case (cmd.mode)
				MODE_TICK: begin
					// Each field increments only when all lower fields roll over.
					// An out-of-range value wraps to zero without carrying.
					if (!halt_q) begin
						if (sec_q != SEC_LAST) begin
							sec_q <= sec_q + 6'd1;
						end else begin
							sec_q <= '0;
							if (min_q != MIN_LAST) begin
								min_q <= min_q + 6'd1;
							end else begin
								min_q <= '0;
								if (hour_q != HOUR_LAST) begin
									hour_q <= hour_q + 5'd1;
								end else begin
									hour_q <= '0;
									day_q  <= day_q + 9'd1;
									if (day_q == DAY_LAST) begin
										carry_q <= 1'b1;
									end
								end
							end
						end
					end
				end
				MODE_READ: begin
				end
				MODE_WRITE: begin
					unique case (cmd.idx)
						REG_SEC:  sec_q  <= cmd.val[5:0];
						REG_MIN:  min_q  <= cmd.val[5:0];
						REG_HOUR: hour_q <= cmd.val[4:0];
						REG_DAYL: day_q[7:0] <= cmd.val;
						REG_CTRL: begin
							day_q[8] <= cmd.val[0];
							halt_q   <= cmd.val[6];
							carry_q  <= cmd.val[7];
						end
						default: begin
						end
					endcase
				end
				MODE_LATCH: begin
					if (!latched_q && cmd.val == LATCH_SET) begin
						for (int k = 0; k < NUM_REGS; k++) begin
							snap_q[k] <= live[k];
						end
						latched_q <= 1'b1;
					end else if (cmd.val == LATCH_CLEAR) begin
						latched_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> design/ccr_out.sv
// This file holds the result register that drives the output channel.
// It depends on ccr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ccr_out (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       load,
	input  wire logic [7:0] data,
	input  wire logic       out_stall,
	output logic            out_free,
	output logic            out_valid,
	output logic [7:0]      read_data
);
	import ccr_pkg::*;

	logic       valid_q;
	logic [7:0] data_q;

	// The register can take a new result when it is empty or is being drained.
	assign out_free  = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign read_data = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && out_free) begin
			data_q <= data;
		end
	end

endmodule

`default_nettype wire
